// ===== hw/rtl/ledusd_pkg.sv =====
package ledusd_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_RED     = 3'd0,
        PH_GREEN   = 3'd1,
        PH_BLUE    = 3'd2,
        PH_COUNT   = 3'd3,
        PH_TARGETS = 3'd4
    } phase_t;

    localparam int QDepth = 4;
    localparam int QAddrW = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // x[6:4] value that selects the column / half-row forms
    localparam logic [2:0] LineGroup = 3'b110;

    // one target byte together with the colour of its record
    typedef struct packed {
        logic [6:0] target;
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
    } target_t;

    function automatic logic [6:0] level_of(logic [5:0] v);
        logic [6:0] lv;
        if (v == 6'd0)
            lv = 7'd0;
        else
            lv = {1'b0, v} + 7'd2;
        return lv;
    endfunction

    // index of the final write of a target byte
    function automatic logic [2:0] last_step(logic [6:0] x);
        logic [2:0] ls;
        if (x[6:4] == LineGroup)
            ls = 3'd7;
        else if (x[6] && x[5])
            ls = 3'd3;
        else if (x[6])
            ls = 3'd1;
        else
            ls = 3'd0;
        return ls;
    endfunction

    function automatic logic [5:0] pad_of(logic [6:0] x, logic [2:0] step);
        logic [5:0] inv;
        logic [5:0] pad;
        inv = ~x[5:0];
        if (x[6:4] != LineGroup) begin
            case (step[1:0])
                2'd0:    pad = x[5:0];
                2'd1:    pad = inv;
                2'd2:    pad = {1'b0, x[4:2], inv[1:0]};
                default: pad = {x[5], inv[4:2], x[1:0]};
            endcase
        end else if (x[3]) begin
            pad = {x[5] & x[2], step, x[1:0]};
        end else begin
            // alternate between the upper and lower half-row
            pad = {step[0], x[2:0], step[2:1]};
        end
        return pad;
    endfunction

endpackage

// ===== hw/rtl/ledusd_front.sv =====
module ledusd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [6:0]           data_byte,
    input  logic                 frame_start,
    output logic                 push,
    output ledusd_pkg::target_t  push_entry
);

    ledusd_pkg::phase_t phase_reg, phase_next;
    logic [5:0] red_reg, red_next;
    logic [5:0] green_reg, green_next;
    logic [5:0] blue_reg, blue_next;
    logic [6:0] left_reg, left_next;
    ledusd_pkg::phase_t cur_phase;
    logic [6:0] left_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ledusd_pkg::PH_RED;
            red_reg   <= 6'd0;
            green_reg <= 6'd0;
            blue_reg  <= 6'd0;
            left_reg  <= 7'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            left_reg  <= left_next;
        end
    end

    assign left_dec = left_reg - 7'd1;

    always_comb
    begin
        phase_next = phase_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        left_next  = left_reg;
        push       = 1'b0;
        push_entry = '{target: data_byte, red: red_reg, green: green_reg, blue: blue_reg};
        cur_phase  = frame_start ? ledusd_pkg::PH_RED : phase_reg;

        if (accept)
        begin
            unique case (cur_phase)
                ledusd_pkg::PH_GREEN:
                begin
                    green_next = data_byte[5:0];
                    left_next  = {left_reg[6:2], data_byte[6], left_reg[0]};
                    phase_next = ledusd_pkg::PH_BLUE;
                end
                ledusd_pkg::PH_BLUE:
                begin
                    blue_next  = data_byte[5:0];
                    left_next  = {4'd0, left_reg[2:1], data_byte[6]};
                    if (left_reg[2:1] == 2'd0 && !data_byte[6])
                        phase_next = ledusd_pkg::PH_COUNT;
                    else
                        phase_next = ledusd_pkg::PH_TARGETS;
                end
                ledusd_pkg::PH_COUNT:
                begin
                    left_next  = data_byte;
                    phase_next = (data_byte == 7'd0) ? ledusd_pkg::PH_RED
                                                     : ledusd_pkg::PH_TARGETS;
                end
                ledusd_pkg::PH_TARGETS:
                begin
                    push      = 1'b1;
                    left_next = left_dec;
                    if (left_dec == 7'd0)
                        phase_next = ledusd_pkg::PH_RED;
                end
                default:
                begin
                    red_next   = data_byte[5:0];
                    left_next  = {4'd0, data_byte[6], 2'd0};
                    phase_next = ledusd_pkg::PH_GREEN;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/ledusd_queue.sv =====
module ledusd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ledusd_pkg::target_t  push_entry,
    input  logic                 pop,
    output ledusd_pkg::target_t  head,
    output logic                 full,
    output logic                 not_empty
);

    ledusd_pkg::target_t entry_reg [ledusd_pkg::QDepth];
    logic [ledusd_pkg::QAddrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ledusd_pkg::QCntW-1:0]  count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == ledusd_pkg::QCntW'(ledusd_pkg::QDepth));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ledusd_pkg::QCntW'(ledusd_pkg::QDepth))
        else $error("queue occupancy out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[ledusd_pkg::QAddrW-1:0])
        else $error("queue pointers disagree with occupancy");

endmodule

// ===== hw/rtl/ledusd_back.sv =====
module ledusd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ledusd_pkg::target_t  head,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [5:0]           led_index,
    output logic [6:0]           red_level,
    output logic [6:0]           green_level,
    output logic [6:0]           blue_level,
    output logic                 last_write
);

    ledusd_pkg::target_t cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg;
    logic [5:0] index_reg;
    logic [6:0] red_reg, green_reg, blue_reg;
    logic       last_reg;
    logic       advance, emit, final_step, load;

    assign advance    = !out_valid_reg || out_ready;
    assign emit       = advance && cur_valid_reg;
    assign final_step = (step_reg == ledusd_pkg::last_step(cur_reg.target));
    assign pop        = head_valid && (!cur_valid_reg || (emit && final_step));
    assign load       = pop;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            step_next      = 3'd0;
        end
        else if (emit)
        begin
            if (final_step)
                cur_valid_next = 1'b0;
            else
                step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            if (advance)
                out_valid_reg <= cur_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= head;
        if (emit)
        begin
            index_reg <= ledusd_pkg::pad_of(cur_reg.target, step_reg);
            red_reg   <= ledusd_pkg::level_of(cur_reg.red);
            green_reg <= ledusd_pkg::level_of(cur_reg.green);
            blue_reg  <= ledusd_pkg::level_of(cur_reg.blue);
            last_reg  <= final_step;
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_index   = index_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;
    assign last_write  = last_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> step_reg <= ledusd_pkg::last_step(cur_reg.target))
        else $error("write step past end of target expansion");

    a_more_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> cur_valid_reg)
        else $error("non-final write shown with no target in work");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && !(emit && final_step)) |-> !pop)
        else $error("queue popped while target still expanding");

endmodule

// ===== hw/rtl/led_update_stream_decompressor_unit.sv =====
// Path: a target byte passes the queue entry, the current-target register and
// the output register to its first LED write; colour and count bytes give none.
// Throughput: one input byte per cycle while the 4-entry queue has room; a target
// byte gives 1, 2, 4 or 8 writes, one per cycle unless out_ready holds them off.
// Reset: rst_n clears the parser to expect a red byte, colours and count to zero,
// and empties the queue and the output register.
module led_update_stream_decompressor_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [6:0] data_byte,
    input  logic       frame_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] led_index,
    output logic [6:0] red_level,
    output logic [6:0] green_level,
    output logic [6:0] blue_level,
    output logic       last_write
);

    ledusd_pkg::target_t push_entry, head;
    logic push, pop, full, not_empty, accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    ledusd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .push        (push),
        .push_entry  (push_entry)
    );

    ledusd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .not_empty  (not_empty)
    );

    ledusd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (not_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .led_index   (led_index),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .last_write  (last_write)
    );

endmodule

// ===== tb/tb_led_update_stream_decompressor_unit.sv =====
`timescale 1ns / 100ps

module tb_led_update_stream_decompressor_unit;

    localparam logic [2:0] LINE_FORMS = ledusd_pkg::LineGroup;
    localparam int RX_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [5:0] led_index;
        logic [6:0] red_level;
        logic [6:0] green_level;
        logic [6:0] blue_level;
        logic       last_write;
    } led_write_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [6:0] data_byte;
    logic       frame_start;
    logic       out_valid;
    logic       out_ready;
    logic [5:0] led_index;
    logic [6:0] red_level;
    logic [6:0] green_level;
    logic [6:0] blue_level;
    logic       last_write;

    // predictor state
    ledusd_pkg::phase_t cur_phase;
    logic [5:0] rec_red;
    logic [5:0] rec_green;
    logic [5:0] rec_blue;
    logic [7:0] targets_todo;
    led_write_t pending_writes[$];

    int  errors;
    int  bytes_sent;
    int  writes_checked;
    bit  tx_idle;
    bit  rx_idle;
    bit  hold_req;
    int  rx_hold_left;
    int  rx_stall_left;

    led_update_stream_decompressor_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .led_index   (led_index),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .last_write  (last_write)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [6:0] stored_level(logic [5:0] v);
        return (v == 6'd0) ? 7'd0 : {1'b0, v} + 7'd2;
    endfunction

    task automatic expand_target(input logic [6:0] x);
        logic [5:0] pads[$];
        logic [5:0] inv;
        logic [5:0] col;
        logic [2:0] k3;
        logic [1:0] k2;
        led_write_t w;
        inv = ~x[5:0];
        if (x[6:4] != LINE_FORMS)
        begin
            pads.push_back(x[5:0]);
            if (x[6])
            begin
                pads.push_back(inv);
                if (x[5])
                begin
                    // remaining two mirror quadrants
                    pads.push_back((x[5:0] & 6'h1C) | (inv & 6'h03));
                    pads.push_back((x[5:0] & 6'h23) | (inv & 6'h1C));
                end
            end
        end
        else if (x[3])
        begin
            col = x[5:0] & (x[2] ? 6'h23 : 6'h03);
            for (int k = 0; k < 8; k++)
            begin
                k3 = k[2:0];
                pads.push_back(col | {1'b0, k3, 2'b00});
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                k2 = k[1:0];
                pads.push_back({1'b0, x[2:0], k2});
                pads.push_back({1'b1, x[2:0], k2});
            end
        end
        foreach (pads[i])
        begin
            w.led_index   = pads[i];
            w.red_level   = stored_level(rec_red);
            w.green_level = stored_level(rec_green);
            w.blue_level  = stored_level(rec_blue);
            w.last_write  = (i == pads.size() - 1);
            pending_writes.push_back(w);
        end
    endtask

    task automatic decode_byte(input logic [6:0] b, input logic fs);
        ledusd_pkg::phase_t ph;
        ph = fs ? ledusd_pkg::PH_RED : cur_phase;
        case (ph)
            ledusd_pkg::PH_GREEN:
            begin
                rec_green    = b[5:0];
                targets_todo = targets_todo | {6'd0, b[6], 1'b0};
                cur_phase    = ledusd_pkg::PH_BLUE;
            end
            ledusd_pkg::PH_BLUE:
            begin
                rec_blue     = b[5:0];
                targets_todo = (targets_todo & 8'h06) | {7'd0, b[6]};
                cur_phase    = (targets_todo == 8'd0) ? ledusd_pkg::PH_COUNT
                                                      : ledusd_pkg::PH_TARGETS;
            end
            ledusd_pkg::PH_COUNT:
            begin
                targets_todo = {1'b0, b};
                cur_phase    = (b == 7'd0) ? ledusd_pkg::PH_RED : ledusd_pkg::PH_TARGETS;
            end
            ledusd_pkg::PH_TARGETS:
            begin
                expand_target(b);
                targets_todo = targets_todo - 8'd1;
                if (targets_todo == 8'd0)
                    cur_phase = ledusd_pkg::PH_RED;
            end
            default:
            begin
                rec_red      = b[5:0];
                targets_todo = {5'd0, b[6], 2'b00};
                cur_phase    = ledusd_pkg::PH_GREEN;
            end
        endcase
    endtask

    task automatic check_write();
        led_write_t got;
        led_write_t exp;
        got = '{led_index, red_level, green_level, blue_level, last_write};
        if (pending_writes.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected LED write idx=%0d r=%0d g=%0d b=%0d last=%0b",
                     $time, got.led_index, got.red_level, got.green_level,
                     got.blue_level, got.last_write);
        end
        else
        begin
            exp = pending_writes.pop_front();
            writes_checked++;
            if (got !== exp)
            begin
                errors++;
                $display("%0t: LED write mismatch: expected idx=%0d r=%0d g=%0d b=%0d last=%0b",
                         $time, exp.led_index, exp.red_level, exp.green_level,
                         exp.blue_level, exp.last_write);
                $display("%0t:   actual idx=%0d r=%0d g=%0d b=%0d last=%0b",
                         $time, got.led_index, got.red_level, got.green_level,
                         got.blue_level, got.last_write);
            end
        end
    endtask

    // both handshakes sampled at the edge, before any driver updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_write();
            if (in_valid && in_ready)
                decode_byte(data_byte, frame_start);
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            rx_hold_left = RX_HOLD_CYCLES;
            hold_req     = 1'b0;
        end
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_stall_left > 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_idle)
                rx_stall_left = pick_gap();
        end
    end

    // called at a rising edge; returns at the edge where the transaction happens
    task automatic send_byte(input logic [6:0] b, input logic fs);
        int gap;
        bit ok;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= fs;
        do
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end while (!ok);
        bytes_sent++;
    endtask

    function automatic logic [5:0] rand_colour();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 6'd0;
        else if (r == 1)
            return 6'h3F;
        else
            return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [6:0] rand_target();
        logic [6:0] x;
        x = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 4))
            0: x[6]   = 1'b0;
            1: x[6:5] = 2'b10;
            2: x[6:4] = 3'b111;
            3: x[6:3] = {LINE_FORMS, 1'b1};
            default: x[6:3] = {LINE_FORMS, 1'b0};
        endcase
        return x;
    endfunction

    task automatic send_random_record();
        int r;
        int n;
        logic [2:0] cnt;
        logic fs;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            // noise: raw bytes, occasional restarts
            n = $urandom_range(1, 6);
            repeat (n) send_byte(7'($urandom_range(0, 127)), ($urandom_range(0, 7) == 0));
        end
        else
        begin
            cnt = (r < 65) ? 3'($urandom_range(1, 7)) : 3'd0;
            fs  = 1'($urandom_range(0, 1));
            send_byte({cnt[2], rand_colour()}, fs);
            send_byte({cnt[1], rand_colour()}, 1'b0);
            send_byte({cnt[0], rand_colour()}, 1'b0);
            n = int'(cnt);
            if (cnt == 3'd0)
            begin
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
                send_byte(7'(n), 1'b0);
            end
            // now and then the record is cut short
            if (n > 0 && $urandom_range(0, 9) == 0)
                n = $urandom_range(0, n - 1);
            repeat (n) send_byte(rand_target(), 1'b0);
        end
    endtask

    task automatic test_directed_forms();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // full 3-bit count, colour extremes, every target form
        send_byte(7'h40, 1'b1);
        send_byte(7'h7F, 1'b0);
        send_byte(7'h41, 1'b0);
        send_byte(7'h00, 1'b0);
        send_byte(7'h3F, 1'b0);
        send_byte(7'h55, 1'b0);
        send_byte(7'h7F, 1'b0);
        send_byte(7'h6F, 1'b0);
        send_byte(7'h6B, 1'b0);
        send_byte(7'h67, 1'b0);
        // explicit count of zero ends the record
        send_byte(7'h00, 1'b0);
        send_byte(7'h00, 1'b0);
        send_byte(7'h00, 1'b0);
        send_byte(7'h00, 1'b0);
        // largest explicit count, then cut short by a restart
        send_byte(7'h01, 1'b0);
        send_byte(7'h02, 1'b0);
        send_byte(7'h03, 1'b0);
        send_byte(7'h7F, 1'b0);
        send_byte(7'h6C, 1'b0);
        send_byte(7'h00, 1'b1);
        send_byte(7'h40, 1'b0);
        send_byte(7'h00, 1'b0);
        send_byte(7'h70, 1'b0);
        send_byte(7'h2A, 1'b0);
    endtask

    task automatic test_random_records(input int n_bytes, input bit with_idling);
        int stop_at;
        tx_idle = with_idling;
        rx_idle = with_idling;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_record();
    endtask

    task automatic test_output_backpressure();
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_req = 1'b1;
        // eight-write targets fill the queue while the output is held off
        send_byte(7'h40, 1'b1);
        send_byte(7'h55, 1'b0);
        send_byte(7'h6A, 1'b0);
        for (int i = 0; i < 7; i++)
            send_byte({LINE_FORMS, 4'($urandom_range(0, 15))}, 1'b0);
    endtask

    initial
    begin
        #5_000_000;
        $display("tb_led_update_stream_decompressor_unit: done, errors");
        $finish;
    end

    initial
    begin
        errors         = 0;
        bytes_sent     = 0;
        writes_checked = 0;
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        hold_req       = 1'b0;
        rx_hold_left   = 0;
        rx_stall_left  = 0;
        cur_phase      = ledusd_pkg::PH_RED;
        rec_red        = 6'd0;
        rec_green      = 6'd0;
        rec_blue       = 6'd0;
        targets_todo   = 8'd0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_byte      <= 7'd0;
        frame_start    <= 1'b0;
        out_ready      <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_forms();
        test_random_records(20, 1'b0);
        test_random_records(50, 1'b1);
        test_output_backpressure();
        in_valid <= 1'b0;

        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d input bytes and %0d LED writes: all target forms, explicit counts,",
                 bytes_sent, writes_checked);
        $display("restarts, truncated records, random idling and a long output hold-off.");
        if (errors == 0)
            $display("tb_led_update_stream_decompressor_unit: done, clean");
        else
            $display("tb_led_update_stream_decompressor_unit: done, errors");
        $finish;
    end

endmodule
